### rtl/core/stp_pkg.sv
// Shared types and constants for the software timer pool.
package stp_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int SLOT_W        = 5;
    localparam int CNT_W         = 32;
    localparam int MASK_W        = 16;

    localparam logic [SLOT_W-1:0] NO_SLOT = 5'd16;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_START      = 3'd1,
        ACT_FREE       = 3'd2,
        ACT_SERVICE    = 3'd3,
        ACT_SET_RELOAD = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SVC,
        ST_TICK_OUT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              accept;
        logic              scan_rd;
        logic [SLOT_W-1:0] scan_idx;
        logic              tick_mode;
        logic              load_tick;
        logic              emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic pend_empty;
        logic pend_last;
    } dp_sts_t;

endpackage

### rtl/core/stp_in_if.sv
// Command channel of the timer pool: valid, ready and the command payload.
interface stp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [4:0]  timer_id;
    logic        timer_type;
    logic [31:0] delay_value;
    logic [31:0] reload_value;

    modport source (
        output valid, action, timer_id, timer_type, delay_value, reload_value,
        input  ready
    );
    modport sink (
        input  valid, action, timer_id, timer_type, delay_value, reload_value,
        output ready
    );
endinterface

### rtl/core/stp_out_if.sv
// Result channel of the timer pool: valid, ready and the result payload.
interface stp_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [4:0]  slot_id;
    logic        fired;
    logic        last;
    logic [15:0] expired_mask;
    logic [15:0] active_mask;

    modport source (
        output valid, status, slot_id, fired, last, expired_mask, active_mask,
        input  ready
    );
    modport sink (
        input  valid, status, slot_id, fired, last, expired_mask, active_mask,
        output ready
    );
endinterface

### rtl/core/software_timer_pool.sv
// Pool of one-shot and periodic timer slots; top level.
// Start, free, set reload and no-op results appear in the cycle after acceptance.
// Tick: one slot count read and updated per cycle across the scan, then a single result.
// Service: after the scan, one event per cycle while the result register is free.
// Throughput: one short command per cycle while results are taken; tick and service block new commands until done.
// Reset clears all slot flags; count and reload memories are written before use.
module software_timer_pool #(
    parameter int NUM_SLOTS = stp_pkg::NUM_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    stp_in_if.sink     req,
    stp_out_if.source  rsp
);

    stp_pkg::ctl_cmd_t cmd;
    stp_pkg::dp_sts_t  sts;
    logic              in_ready;

    assign req.ready = in_ready;

    stp_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .action   (req.action),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    stp_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .action       (req.action),
        .timer_id     (req.timer_id),
        .timer_type   (req.timer_type),
        .delay_value  (req.delay_value),
        .reload_value (req.reload_value),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .status       (rsp.status),
        .slot_id      (rsp.slot_id),
        .fired        (rsp.fired),
        .last         (rsp.last),
        .expired_mask (rsp.expired_mask),
        .active_mask  (rsp.active_mask)
    );

endmodule

### rtl/core/stp_ctrl.sv
// Timer pool controller: command sequencing and slot scan counter.
module stp_ctrl #(
    parameter int NUM_SLOTS = stp_pkg::NUM_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [2:0]           action,
    input  stp_pkg::dp_sts_t     sts,
    output logic                 in_ready,
    output stp_pkg::ctl_cmd_t    cmd
);

    localparam logic [stp_pkg::SLOT_W-1:0] LAST_CNT = stp_pkg::SLOT_W'(NUM_SLOTS);

    stp_pkg::state_t              state_reg, state_next;
    logic [stp_pkg::SLOT_W-1:0]   cnt_reg, cnt_next;
    logic                         accept;
    logic                         scanning;
    stp_pkg::action_t             act;

    assign act      = stp_pkg::action_t'(action);
    assign in_ready = (state_reg == stp_pkg::ST_IDLE) && sts.out_free;
    assign accept   = in_ready && in_valid;
    assign scanning = (state_reg == stp_pkg::ST_TICK) || (state_reg == stp_pkg::ST_SVC);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stp_pkg::ST_IDLE:
            begin
                if (accept && act == stp_pkg::ACT_TICK)
                    state_next = stp_pkg::ST_TICK;
                else if (accept && act == stp_pkg::ACT_SERVICE)
                    state_next = stp_pkg::ST_SVC;
            end
            stp_pkg::ST_TICK:
            begin
                if (cnt_reg == LAST_CNT)
                    state_next = stp_pkg::ST_TICK_OUT;
            end
            stp_pkg::ST_SVC:
            begin
                if (cnt_reg == LAST_CNT)
                    state_next = stp_pkg::ST_EMIT;
            end
            stp_pkg::ST_TICK_OUT:
            begin
                if (sts.out_free)
                    state_next = stp_pkg::ST_IDLE;
            end
            stp_pkg::ST_EMIT:
            begin
                if (sts.out_free && (sts.pend_empty || sts.pend_last))
                    state_next = stp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = stp_pkg::ST_IDLE;
            end
        endcase
    end

    // Scan counter: one slot read per cycle; the final count issues no read and drains the last write.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
            cnt_next = '0;
        else if (scanning && cnt_reg != LAST_CNT)
            cnt_next = cnt_reg + 1'b1;
    end

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.scan_rd   = scanning && (cnt_reg != LAST_CNT);
        cmd.scan_idx  = cnt_reg;
        cmd.tick_mode = (state_reg == stp_pkg::ST_TICK);
        cmd.load_tick = (state_reg == stp_pkg::ST_TICK_OUT) && sts.out_free;
        cmd.emit      = (state_reg == stp_pkg::ST_EMIT) && sts.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stp_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_CNT)
        else $error("scan counter ran past the last slot");

    a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == stp_pkg::ST_TICK && cnt_reg == LAST_CNT |=>
            state_reg == stp_pkg::ST_TICK_OUT)
        else $error("tick scan did not finish");

    a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && sts.pend_empty |=> state_reg == stp_pkg::ST_IDLE)
        else $error("service with no expired slot did not return to idle");

endmodule

### rtl/core/stp_dpath.sv
// Timer pool datapath: slot flags, count and reload memories, result register.
module stp_dpath #(
    parameter int NUM_SLOTS = stp_pkg::NUM_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stp_pkg::ctl_cmd_t   cmd,
    output stp_pkg::dp_sts_t    sts,
    input  logic [2:0]          action,
    input  logic [4:0]          timer_id,
    input  logic                timer_type,
    input  logic [31:0]         delay_value,
    input  logic [31:0]         reload_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                status,
    output logic [4:0]          slot_id,
    output logic                fired,
    output logic                last,
    output logic [15:0]         expired_mask,
    output logic [15:0]         active_mask
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [NUM_SLOTS-1:0] ONE_BIT = NUM_SLOTS'(1);

    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_SLOTS-1:0] expired_reg, expired_next;
    logic [NUM_SLOTS-1:0] periodic_reg, periodic_next;
    logic [NUM_SLOTS-1:0] pend_reg, pend_next;

    logic [stp_pkg::CNT_W-1:0] tick_mem   [NUM_SLOTS];
    logic [stp_pkg::CNT_W-1:0] reload_mem [NUM_SLOTS];
    logic [stp_pkg::CNT_W-1:0] tick_rd_reg;
    logic [stp_pkg::CNT_W-1:0] reload_rd_reg;

    logic                 p_vld_reg;
    logic [IDX_W-1:0]     p_idx_reg;
    logic                 p_tick_reg;

    logic                        out_valid_reg, out_valid_next;
    logic                        status_reg, status_next;
    logic [stp_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic                        fired_reg, fired_next;
    logic                        last_reg, last_next;
    logic [NUM_SLOTS-1:0]        exp_out_reg, exp_out_next;
    logic [NUM_SLOTS-1:0]        act_out_reg, act_out_next;

    stp_pkg::action_t     act;
    logic                 is_start, is_free, is_svc, is_setrel, is_simple;
    logic                 id_ok;
    logic [IDX_W-1:0]     id_idx;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     pend_idx;
    logic                 pend_empty, pend_last;
    logic                 out_free;
    logic                 tick_hit, svc_hit;
    logic [NUM_SLOTS-1:0] p_bit;

    logic                       tick_we;
    logic [IDX_W-1:0]           tick_waddr;
    logic [stp_pkg::CNT_W-1:0]  tick_wdata;
    logic                       reload_we;
    logic [IDX_W-1:0]           reload_waddr;

    assign act       = stp_pkg::action_t'(action);
    assign is_start  = cmd.accept && (act == stp_pkg::ACT_START);
    assign is_free   = cmd.accept && (act == stp_pkg::ACT_FREE);
    assign is_svc    = cmd.accept && (act == stp_pkg::ACT_SERVICE);
    assign is_setrel = cmd.accept && (act == stp_pkg::ACT_SET_RELOAD);
    assign is_simple = cmd.accept && (act != stp_pkg::ACT_TICK) && (act != stp_pkg::ACT_SERVICE);
    assign id_ok     = timer_id < stp_pkg::SLOT_W'(NUM_SLOTS);
    assign id_idx    = timer_id[IDX_W-1:0];
    assign out_free  = !out_valid_reg || out_ready;

    // Lowest free slot and lowest pending expired slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        pend_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (pend_reg[i])
                pend_idx = IDX_W'(i);
        end
    end

    assign pend_empty = (pend_reg == '0);
    assign pend_last  = ((pend_reg & (pend_reg - ONE_BIT)) == '0);

    assign sts.out_free   = out_free;
    assign sts.pend_empty = pend_empty;
    assign sts.pend_last  = pend_last;

    assign p_bit    = ONE_BIT << p_idx_reg;
    assign tick_hit = p_vld_reg && p_tick_reg && active_reg[p_idx_reg] && (tick_rd_reg != '0);
    assign svc_hit  = p_vld_reg && !p_tick_reg && pend_reg[p_idx_reg] && periodic_reg[p_idx_reg];

    // Count memory write port.
    always_comb
    begin
        tick_we    = 1'b0;
        tick_waddr = p_idx_reg;
        tick_wdata = reload_rd_reg;
        if (is_start && free_found)
        begin
            tick_we    = 1'b1;
            tick_waddr = free_idx;
            tick_wdata = (delay_value == '0) ? stp_pkg::CNT_W'(1) : delay_value;
        end
        else if (tick_hit)
        begin
            tick_we    = 1'b1;
            tick_wdata = tick_rd_reg - 1'b1;
        end
        else if (svc_hit)
        begin
            tick_we = 1'b1;
        end
    end

    // Reload memory write port.
    always_comb
    begin
        reload_we    = 1'b0;
        reload_waddr = free_idx;
        if (is_start && free_found)
        begin
            reload_we = 1'b1;
        end
        else if (is_setrel && id_ok)
        begin
            reload_we    = 1'b1;
            reload_waddr = id_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_we)
            tick_mem[tick_waddr] <= tick_wdata;
        if (cmd.scan_rd)
            tick_rd_reg <= tick_mem[cmd.scan_idx[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (reload_we)
            reload_mem[reload_waddr] <= reload_value;
        if (cmd.scan_rd)
            reload_rd_reg <= reload_mem[cmd.scan_idx[IDX_W-1:0]];
    end

    // Slot flags.
    always_comb
    begin
        active_next   = active_reg;
        expired_next  = expired_reg;
        periodic_next = periodic_reg;
        pend_next     = pend_reg;
        if (is_start && free_found)
        begin
            active_next[free_idx]   = 1'b1;
            periodic_next[free_idx] = timer_type;
        end
        if (is_free && id_ok)
        begin
            active_next[id_idx]  = 1'b0;
            expired_next[id_idx] = 1'b0;
        end
        // Service: periodic slots drop their mark, one-shot slots are released.
        if (is_svc)
        begin
            pend_next    = expired_reg;
            expired_next = '0;
            active_next  = active_reg & ~(expired_reg & ~periodic_reg);
        end
        if (tick_hit && tick_rd_reg == stp_pkg::CNT_W'(1))
            expired_next = expired_reg | p_bit;
        if (cmd.emit && !pend_empty)
            pend_next[pend_idx] = 1'b0;
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        slot_next      = slot_reg;
        fired_next     = fired_reg;
        last_next      = last_reg;
        exp_out_next   = exp_out_reg;
        act_out_next   = act_out_reg;
        if (is_simple || cmd.load_tick || cmd.emit)
        begin
            out_valid_next = 1'b1;
            status_next    = 1'b0;
            slot_next      = stp_pkg::NO_SLOT;
            fired_next     = 1'b0;
            last_next      = 1'b1;
            exp_out_next   = expired_next;
            act_out_next   = active_next;
            if (is_start)
            begin
                status_next = !free_found;
                if (free_found)
                    slot_next = stp_pkg::SLOT_W'(free_idx);
            end
            if (cmd.emit && !pend_empty)
            begin
                slot_next  = stp_pkg::SLOT_W'(pend_idx);
                fired_next = 1'b1;
                last_next  = pend_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            expired_reg   <= '0;
            periodic_reg  <= '0;
            pend_reg      <= '0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            expired_reg   <= expired_next;
            periodic_reg  <= periodic_next;
            pend_reg      <= pend_next;
            p_vld_reg     <= cmd.scan_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg   <= cmd.scan_idx[IDX_W-1:0];
        p_tick_reg  <= cmd.tick_mode;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        fired_reg   <= fired_next;
        last_reg    <= last_next;
        exp_out_reg <= exp_out_next;
        act_out_reg <= act_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot_id      = slot_reg;
    assign fired        = fired_reg;
    assign last         = last_reg;
    assign expired_mask = stp_pkg::MASK_W'(exp_out_reg);
    assign active_mask  = stp_pkg::MASK_W'(act_out_reg);

    a_expired_active: assert property (@(posedge clk) disable iff (!rst_n)
        (expired_reg & ~active_reg) == '0)
        else $error("expired mark on an inactive slot");

    a_svc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        is_svc |=> expired_reg == '0)
        else $error("service left an expired mark");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (is_simple || cmd.load_tick || cmd.emit) |-> out_free)
        else $error("result loaded over a pending transaction");

endmodule
